// ===== src/est_pkg.sv =====
// ----------------------------------------------------------------------------
// est_pkg
// Shared types and constants of the ELF64 segment table checker.
// ----------------------------------------------------------------------------
`default_nettype none

package est_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IMG_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_ADDR = 2'd3;

    // Parameter defaults
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int MAX_PAGES_DEF  = 256;

    // Field widths
    localparam int ADDR_W      = 64;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 4;
    localparam int VERDICT_W   = 3;
    localparam int PAGES_OUT_W = 9;

    // Header constants
    localparam logic [WORD_W-1:0] SEG_KIND_LOAD = 32'd1;
    localparam logic [WORD_W-1:0] PERM_EXEC     = 32'h0000_0001;
    localparam logic [WORD_W-1:0] PERM_WRITE    = 32'h0000_0002;
    localparam logic [WORD_W-1:0] PERM_READ     = 32'h0000_0004;
    localparam logic [WORD_W-1:0] PERM_KNOWN    = PERM_READ | PERM_WRITE | PERM_EXEC;
    localparam logic [WORD_W-1:0] PERM_WX       = PERM_WRITE | PERM_EXEC;

    // Per-entry status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT  = 4'd0,
        ST_SKIP    = 4'd1,
        ST_SIZE    = 4'd2,
        ST_FLAGS   = 4'd3,
        ST_WX      = 4'd4,
        ST_ALIGN   = 4'd5,
        ST_WINDOW  = 4'd6,
        ST_BUDGET  = 4'd7,
        ST_IGNORED = 4'd8
    } t_status;

    // Table verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        V_PENDING    = 3'd0,
        V_ACCEPTED   = 3'd1,
        V_REJECTED   = 3'd2,
        V_NO_LOAD    = 3'd3,
        V_NO_ENTRY   = 3'd4,
        V_BAD_WINDOW = 3'd5
    } t_verdict;

    // Classified entry handed from the front end to the back end
    typedef struct packed {
        logic    last;
        logic    load;
        t_status code;
        logic    hit;
    } t_seg_cls;

endpackage

`default_nettype wire

// ===== src/est_if.sv =====
// ----------------------------------------------------------------------------
// est_if
// Valid/ready channels: program header entries in, entry results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface est_seg_if;
    logic        valid;
    logic        ready;
    logic [31:0] segment_kind;
    logic [31:0] permission_bits;
    logic [63:0] file_offset;
    logic [63:0] virt_base;
    logic [63:0] bytes_in_file;
    logic [63:0] bytes_in_memory;
    logic [63:0] align_amount;
    logic        final_entry;

    modport source (
        output valid, segment_kind, permission_bits, file_offset, virt_base,
               bytes_in_file, bytes_in_memory, align_amount, final_entry,
        input  ready
    );
    modport sink (
        input  valid, segment_kind, permission_bits, file_offset, virt_base,
               bytes_in_file, bytes_in_memory, align_amount, final_entry,
        output ready
    );
endinterface

interface est_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] entry_status;
    logic [2:0] image_verdict;
    logic [8:0] pages_counted;
    logic       verdict_final;

    modport source (
        output valid, entry_status, image_verdict, pages_counted, verdict_final,
        input  ready
    );
    modport sink (
        input  valid, entry_status, image_verdict, pages_counted, verdict_final,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/est_front.sv =====
// ----------------------------------------------------------------------------
// est_front
// Accept header entries and classify them: size, range, flags, alignment,
// window and page count, all independent of the running table state.
// ----------------------------------------------------------------------------
`default_nettype none

module est_front #(
    parameter int PAGE_SHIFT = est_pkg::PAGE_SHIFT_DEF,
    localparam int PG_W      = est_pkg::ADDR_W - PAGE_SHIFT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    est_seg_if.sink                           i_seg,
    input  wire logic [est_pkg::ADDR_W-1:0]   i_img_size,
    input  wire logic [est_pkg::ADDR_W-1:0]   i_win_low,
    input  wire logic [est_pkg::ADDR_W-1:0]   i_win_high,
    input  wire logic [est_pkg::ADDR_W-1:0]   i_entry_addr,
    input  wire logic                         i_q_full,
    output logic                              o_q_push,
    output est_pkg::t_seg_cls                 o_q_cls,
    output logic [PG_W-1:0]                   o_q_pages
);

    // Stage 1 registers
    logic                        r_s1_valid;
    logic                        r_s1_load;
    logic                        r_s1_last;
    est_pkg::t_status            r_s1_code;
    logic                        r_s1_zero;
    logic                        r_s1_hit;
    logic                        r_s1_carry;
    logic                        r_s1_low_fail;
    logic [est_pkg::ADDR_W-1:0]  r_s1_end;
    logic [PG_W-1:0]             r_s1_va_pg;

    // Stage 1 checks
    logic                        accept;
    logic [est_pkg::ADDR_W-1:0]  room;
    logic [est_pkg::ADDR_W-1:0]  algn_m1;
    logic [est_pkg::ADDR_W-1:0]  entry_ofs;
    logic                        algn_bad;
    logic                        hit;
    logic [est_pkg::ADDR_W:0]    end_sum;
    est_pkg::t_status            code1;

    // Stage 2 checks
    logic                        high_fail;
    logic                        low_nz;
    logic                        round_ovf;
    logic [PG_W-1:0]             pages;
    est_pkg::t_status            code2;

    assign accept      = i_seg.valid && i_seg.ready;
    assign i_seg.ready = !r_s1_valid || !i_q_full;
    assign o_q_push    = r_s1_valid && !i_q_full;

    // Classify the incoming entry
    always_comb begin
        room      = i_img_size - i_seg.file_offset;
        algn_m1   = i_seg.align_amount - 64'd1;
        algn_bad  = (i_seg.align_amount > 64'd1) &&
                    (((i_seg.align_amount & algn_m1) != '0) ||
                     (((i_seg.virt_base ^ i_seg.file_offset) & algn_m1) != '0));
        entry_ofs = i_entry_addr - i_seg.virt_base;
        hit       = ((i_seg.permission_bits & est_pkg::PERM_EXEC) != '0) &&
                    (i_entry_addr >= i_seg.virt_base) &&
                    (entry_ofs < i_seg.bytes_in_memory);
        end_sum   = {1'b0, i_seg.virt_base} + {1'b0, i_seg.bytes_in_memory};

        if (i_seg.bytes_in_file > i_seg.bytes_in_memory) begin
            code1 = est_pkg::ST_SIZE;
        end else if (i_seg.file_offset > i_img_size || i_seg.bytes_in_file > room) begin
            code1 = est_pkg::ST_SIZE;
        end else if ((i_seg.permission_bits & ~est_pkg::PERM_KNOWN) != '0 ||
                     (i_seg.permission_bits & est_pkg::PERM_KNOWN) == '0) begin
            code1 = est_pkg::ST_FLAGS;
        end else if ((i_seg.permission_bits & est_pkg::PERM_WX) == est_pkg::PERM_WX) begin
            code1 = est_pkg::ST_WX;
        end else if (algn_bad) begin
            code1 = est_pkg::ST_ALIGN;
        end else begin
            code1 = est_pkg::ST_ACCEPT;
        end
    end

    // Hold stage 1 while the queue is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_seg.ready) begin
            r_s1_valid <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_load     <= (i_seg.segment_kind == est_pkg::SEG_KIND_LOAD);
            r_s1_last     <= i_seg.final_entry;
            r_s1_code     <= code1;
            r_s1_zero     <= (i_seg.bytes_in_memory == '0);
            r_s1_hit      <= hit;
            r_s1_carry    <= end_sum[est_pkg::ADDR_W];
            r_s1_low_fail <= (i_seg.virt_base < i_win_low);
            r_s1_end      <= end_sum[est_pkg::ADDR_W-1:0];
            r_s1_va_pg    <= i_seg.virt_base[est_pkg::ADDR_W-1:PAGE_SHIFT];
        end
    end

    // Window, page rounding and page count
    always_comb begin
        high_fail = (r_s1_end > i_win_high);
        low_nz    = |r_s1_end[PAGE_SHIFT-1:0];
        round_ovf = (&r_s1_end[est_pkg::ADDR_W-1:PAGE_SHIFT]) && low_nz;
        pages     = r_s1_end[est_pkg::ADDR_W-1:PAGE_SHIFT] + PG_W'(low_nz) - r_s1_va_pg;

        if (r_s1_code != est_pkg::ST_ACCEPT) begin
            code2 = r_s1_code;
        end else if (r_s1_zero) begin
            code2 = est_pkg::ST_ACCEPT;
        end else if (r_s1_carry || r_s1_low_fail || high_fail || round_ovf) begin
            code2 = est_pkg::ST_WINDOW;
        end else begin
            code2 = est_pkg::ST_ACCEPT;
        end

        o_q_cls.last = r_s1_last;
        o_q_cls.load = r_s1_load;
        o_q_cls.code = code2;
        o_q_cls.hit  = r_s1_hit;
        o_q_pages    = (code2 == est_pkg::ST_ACCEPT && !r_s1_zero) ? pages : '0;
    end

endmodule

`default_nettype wire

// ===== src/est_queue.sv =====
// ----------------------------------------------------------------------------
// est_queue
// Two-entry queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module est_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_not_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_data      = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/est_back.sv =====
// ----------------------------------------------------------------------------
// est_back
// Apply classified entries to the table state: sticky failure, page budget,
// entry point tracking, and the verdict on the final entry.
// ----------------------------------------------------------------------------
`default_nettype none

module est_back #(
    parameter int PAGE_SHIFT = est_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_PAGES  = est_pkg::MAX_PAGES_DEF,
    localparam int PG_W      = est_pkg::ADDR_W - PAGE_SHIFT,
    localparam int PW        = $clog2(MAX_PAGES + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire est_pkg::t_seg_cls           i_q_cls,
    input  wire logic [PG_W-1:0]             i_q_pages,
    output logic                             o_q_pop,
    input  wire logic [est_pkg::ADDR_W-1:0]  i_win_low,
    input  wire logic [est_pkg::ADDR_W-1:0]  i_win_high,
    est_res_if.source                        o_res
);

    // Table state
    logic            r_fail;
    logic            r_load_seen;
    logic            r_entry_ok;
    logic [PW-1:0]   r_total;

    // Output register
    logic                              r_out_valid;
    logic [est_pkg::STATUS_W-1:0]      r_status;
    logic [est_pkg::VERDICT_W-1:0]     r_verdict;
    logic [est_pkg::PAGES_OUT_W-1:0]   r_pages;
    logic                              r_final;

    logic                                 take;
    logic                                 pages_over;
    logic [PW:0]                          sum;
    logic                                 bad_window;
    est_pkg::t_status                     st;
    est_pkg::t_verdict                    verdict;
    logic                                 n_fail;
    logic                                 n_load_seen;
    logic                                 n_entry_ok;
    logic [PW-1:0]                        n_total;
    logic [PW+est_pkg::PAGES_OUT_W-1:0]   total_ext;

    assign take    = i_q_valid && (!r_out_valid || o_res.ready);
    assign o_q_pop = take;

    // Work out status, next state and verdict for the head entry
    always_comb begin
        pages_over  = (i_q_pages > PG_W'(MAX_PAGES));
        sum         = {1'b0, r_total} + {1'b0, i_q_pages[PW-1:0]};
        bad_window  = (i_win_low >= i_win_high) ||
                      (|i_win_low[PAGE_SHIFT-1:0]) ||
                      (|i_win_high[PAGE_SHIFT-1:0]);
        n_fail      = r_fail;
        n_load_seen = r_load_seen;
        n_entry_ok  = r_entry_ok;
        n_total     = r_total;

        if (r_fail) begin
            st = est_pkg::ST_IGNORED;
        end else if (!i_q_cls.load) begin
            st = est_pkg::ST_SKIP;
        end else begin
            n_load_seen = 1'b1;
            if (i_q_cls.code != est_pkg::ST_ACCEPT) begin
                st = i_q_cls.code;
            end else if (pages_over || sum > (PW+1)'(MAX_PAGES)) begin
                st = est_pkg::ST_BUDGET;
            end else begin
                st      = est_pkg::ST_ACCEPT;
                n_total = sum[PW-1:0];
            end
            if (st != est_pkg::ST_ACCEPT) begin
                n_fail = 1'b1;
            end else if (i_q_cls.hit) begin
                n_entry_ok = 1'b1;
            end
        end

        if (!i_q_cls.last) begin
            verdict = est_pkg::V_PENDING;
        end else if (bad_window) begin
            verdict = est_pkg::V_BAD_WINDOW;
        end else if (n_fail) begin
            verdict = est_pkg::V_REJECTED;
        end else if (!n_load_seen) begin
            verdict = est_pkg::V_NO_LOAD;
        end else if (!n_entry_ok) begin
            verdict = est_pkg::V_NO_ENTRY;
        end else begin
            verdict = est_pkg::V_ACCEPTED;
        end

        total_ext = {{est_pkg::PAGES_OUT_W{1'b0}}, n_total};
    end

    // Update table state; clear it after the final entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail      <= 1'b0;
            r_load_seen <= 1'b0;
            r_entry_ok  <= 1'b0;
            r_total     <= '0;
        end else if (take) begin
            if (i_q_cls.last) begin
                r_fail      <= 1'b0;
                r_load_seen <= 1'b0;
                r_entry_ok  <= 1'b0;
                r_total     <= '0;
            end else begin
                r_fail      <= n_fail;
                r_load_seen <= n_load_seen;
                r_entry_ok  <= n_entry_ok;
                r_total     <= n_total;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status  <= st;
            r_verdict <= verdict;
            r_pages   <= total_ext[est_pkg::PAGES_OUT_W-1:0];
            r_final   <= i_q_cls.last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.entry_status  = r_status;
    assign o_res.image_verdict = r_verdict;
    assign o_res.pages_counted = r_pages;
    assign o_res.verdict_final = r_final;

endmodule

`default_nettype wire

// ===== src/elf_segment_table_checker.sv =====
// Result path: an accepted entry passes the front stage register, a queue slot
// and the output register in that order (the accepting edge loads the first);
// the result is held back longer while the output side stalls.
// Throughput: one entry per cycle while the output side does not stall; front
// and back end each run at one beat per cycle, and the two-entry queue absorbs short stalls.
// Reset: synchronous, active low; clears the table state, queue, valids and
// the configuration registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
// elf_segment_table_checker
// Validates a stream of ELF64 program header entries against the image size,
// the user address window and a page budget, and gives a table verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module elf_segment_table_checker #(
    parameter int PAGE_SHIFT = est_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_PAGES  = est_pkg::MAX_PAGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    est_seg_if.sink                              i_seg,
    est_res_if.source                            o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [est_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [est_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PG_W  = est_pkg::ADDR_W - PAGE_SHIFT;
    localparam int CLS_W = $bits(est_pkg::t_seg_cls);
    localparam int Q_W   = CLS_W + PG_W;

    // Configuration registers
    logic [est_pkg::ADDR_W-1:0] r_img_size;
    logic [est_pkg::ADDR_W-1:0] r_win_low;
    logic [est_pkg::ADDR_W-1:0] r_win_high;
    logic [est_pkg::ADDR_W-1:0] r_entry_addr;

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_not_empty;
    est_pkg::t_seg_cls    push_cls;
    logic [PG_W-1:0]      push_pages;
    logic [Q_W-1:0]       q_head;
    est_pkg::t_seg_cls    head_cls;
    logic [PG_W-1:0]      head_pages;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_size   <= '0;
            r_win_low    <= '0;
            r_win_high   <= '0;
            r_entry_addr <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                est_pkg::CFG_IMG_SIZE:   r_img_size   <= i_cfg_data;
                est_pkg::CFG_WIN_LOW:    r_win_low    <= i_cfg_data;
                est_pkg::CFG_WIN_HIGH:   r_win_high   <= i_cfg_data;
                est_pkg::CFG_ENTRY_ADDR: r_entry_addr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    est_front #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg         (i_seg),
        .i_img_size    (r_img_size),
        .i_win_low     (r_win_low),
        .i_win_high    (r_win_high),
        .i_entry_addr  (r_entry_addr),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cls       (push_cls),
        .o_q_pages     (push_pages)
    );

    est_queue #(
        .W (Q_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_data      ({push_cls, push_pages}),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_data      (q_head),
        .o_not_empty (q_not_empty)
    );

    assign head_cls   = est_pkg::t_seg_cls'(q_head[Q_W-1:PG_W]);
    assign head_pages = q_head[PG_W-1:0];

    est_back #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .MAX_PAGES  (MAX_PAGES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_not_empty),
        .i_q_cls    (head_cls),
        .i_q_pages  (head_pages),
        .o_q_pop    (q_pop),
        .i_win_low  (r_win_low),
        .i_win_high (r_win_high),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    // Front end never pushes into a full queue
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // Back end only pops a held beat
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_not_empty)
        else $error("queue pop while empty");

    // Only the closing beat carries a verdict
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.verdict_final) |->
        (o_res.image_verdict == est_pkg::V_PENDING))
        else $error("verdict on a non-final beat");

    // A failing final entry cannot yield an accepting verdict
    a_fail_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.verdict_final &&
         (o_res.entry_status == est_pkg::ST_SIZE ||
          o_res.entry_status == est_pkg::ST_FLAGS ||
          o_res.entry_status == est_pkg::ST_WX ||
          o_res.entry_status == est_pkg::ST_ALIGN ||
          o_res.entry_status == est_pkg::ST_WINDOW ||
          o_res.entry_status == est_pkg::ST_BUDGET)) |->
        (o_res.image_verdict == est_pkg::V_REJECTED ||
         o_res.image_verdict == est_pkg::V_BAD_WINDOW))
        else $error("failed final entry without reject verdict");
`endif

endmodule

`default_nettype wire
